// ===== sv/fdpf_pkg.sv =====
// Package for the fixed distance pair finder.
// Holds command, status and register codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package fdpf_pkg;

  // Width of the configuration registers and of the index fields.
  localparam int CFG_W = 17;
  localparam int IDX_W = 6;
  // Width of the squared distance bounds.
  localparam int BND_W = 36;

  // Configuration register indexes.
  localparam logic REG_PAIR_DIST = 1'b0;
  localparam logic REG_TOL       = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PAIR      = 2'd0,
    ST_NO_PAIR   = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

// ===== sv/fdpf_cell.sv =====
// One storage cell of the point chain.
// Holds one packed point and hands it to its neighbor when the chain rotates.
// Depends on fdpf_pkg.
`timescale 1ns / 1ps

module fdpf_cell
  import fdpf_pkg::*;
#(
  parameter int PW = 48
) (
  input  logic          clk,
  input  logic          shift_en,
  input  logic [PW-1:0] shift_in,
  input  logic          load_en,
  input  logic [PW-1:0] load_pt,
  output logic [PW-1:0] pt_out
);

  logic [PW-1:0] pt_r;

  // Rotation has priority; loads only happen while the chain is at rest.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pt_r <= shift_in;
    end else if (load_en) begin
      pt_r <= load_pt;
    end
  end

  assign pt_out = pt_r;

endmodule

// ===== sv/fdpf_dist.sv =====
// Three-stage squared distance unit with the window compare.
// Stage one takes absolute differences, stage two squares, stage three sums and compares.
// Depends on fdpf_pkg.
`timescale 1ns / 1ps

module fdpf_dist
  import fdpf_pkg::*;
#(
  parameter int CB = 16,
  parameter int IW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [IW-1:0]   in_idx,
  input  logic [3*CB-1:0] pa,
  input  logic [3*CB-1:0] pb,
  input  logic [BND_W-1:0] lo2,
  input  logic [BND_W-1:0] hi2,
  output logic            hit_v,
  output logic [IW-1:0]   hit_idx
);

  localparam int SQW  = 2 * CB;
  localparam int SW   = SQW + 2;
  localparam int CMPW = (SW > BND_W) ? SW : BND_W;

  logic [CB-1:0]  mag_nxt [3];
  logic [CB-1:0]  mag_r   [3];
  logic [SQW-1:0] sq_r    [3];
  logic           v1_r, v2_r, hit_v_r;
  logic [IW-1:0]  i1_r, i2_r, hit_idx_r;
  logic [SW-1:0]  sum;
  logic [CMPW-1:0] sum_x, lo_x, hi_x;

  // Absolute coordinate differences.
  always_comb begin
    logic signed [CB:0] df;
    logic        [CB:0] ng;
    for (int k = 0; k < 3; k++) begin
      df = $signed({pa[k*CB+CB-1], pa[k*CB +: CB]}) - $signed({pb[k*CB+CB-1], pb[k*CB +: CB]});
      ng = -df;
      mag_nxt[k] = df[CB] ? ng[CB-1:0] : df[CB-1:0];
    end
  end

  // Sum of squares and window test.
  assign sum   = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  assign sum_x = CMPW'(sum);
  assign lo_x  = CMPW'(lo2);
  assign hi_x  = CMPW'(hi2);

  // Control bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      hit_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_v;
      v2_r    <= v1_r;
      hit_v_r <= v2_r && (sum_x >= lo_x) && (sum_x <= hi_x);
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      i1_r      <= in_idx;
      i2_r      <= i1_r;
      hit_idx_r <= i2_r;
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= mag_nxt[k];
        sq_r[k]  <= mag_r[k] * mag_r[k];
      end
    end
  end

  assign hit_v   = hit_v_r;
  assign hit_idx = hit_idx_r;

endmodule

// ===== sv/fixed_distance_pair_finder_unit.sv =====
// Top level of the fixed distance pair finder: point chain, distance unit, controller.
// Depends on fdpf_pkg, fdpf_cell and fdpf_dist.
//
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  cmd, coord_x/y/z, query_index
// out       output     out_valid/out_stall status, first_index, second_index, last
// cfg       input      cfg_we             cfg_index, cfg_wdata
//
// Load, clear and no-op items are handled in the idle state; a load into a full
// store or a bad query index puts one result in the output register.
// A query makes one full rotation of the point chain to pick up the queried point,
// one rotation through the distance unit, a drain of its pipeline and a final step
// for the final result. Output stalls hold the walk, the drain and the final step.
// Reset clears the point count, the configuration and all control state.
`timescale 1ns / 1ps

module fixed_distance_pair_finder_unit
  import fdpf_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic [IDX_W-1:0]      in_query_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [IDX_W-1:0]      out_first_index,
  output logic [IDX_W-1:0]      out_second_index,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = IW + 1;
  localparam int PW   = 3 * COORD_BITS;
  localparam int QW   = CNTW + IDX_W;

  state_t state_r, state_nxt;
  logic [IW-1:0]    step_r, step_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0] q_r, q_nxt;
  logic [PW-1:0]    qpt_r;
  logic             qpt_cap;
  logic [1:0]       drain_r, drain_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IW-1:0]    pend_idx_r, pend_idx_nxt;
  logic             out_v_r, out_v_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [IDX_W-1:0] out_fi_r, out_fi_nxt, out_si_r, out_si_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CFG_W-1:0] pd_r, tol_r;
  logic [BND_W-1:0] lo2_r, hi2_r;
  logic [CFG_W-1:0] lo_b;
  logic [CFG_W:0]   hi_b;
  logic [BND_W-1:0] lo_w, hi_w;

  logic          in_fire, adv, rotate, load_fire, full, feed_v, dist_en;
  logic          step_last;
  logic [PW-1:0] cell_pt [MAX_POINTS];
  logic [PW-1:0] load_pt;
  logic          hit_v;
  logic [IW-1:0] hit_idx;
  logic [IW+IDX_W-1:0] pend_ext;
  logic [IW+IDX_W-1:0] step_ext;

  // Handshake: the output slot is free when empty or being transferred.
  assign adv      = !out_v_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_v_r && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign full     = (cnt_r == CNTW'(MAX_POINTS));
  assign load_fire = in_fire && (in_cmd == CMD_LOAD) && !full;
  assign load_pt  = {in_coord_z, in_coord_y, in_coord_x};
  assign step_last = (step_r == IW'(MAX_POINTS - 1));
  assign pend_ext = {{IDX_W{1'b0}}, pend_idx_r};
  assign step_ext = {{IDX_W{1'b0}}, step_r};

  // Configuration registers and the squared bounds.
  assign lo_b = (pd_r > tol_r) ? (pd_r - tol_r) : '0;
  assign hi_b = {1'b0, pd_r} + {1'b0, tol_r};
  // The bounds are widened first so that the squares keep all their bits.
  assign lo_w = BND_W'(lo_b);
  assign hi_w = BND_W'(hi_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r  <= '0;
      tol_r <= '0;
      lo2_r <= '0;
      hi2_r <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_PAIR_DIST) begin
        pd_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_TOL) begin
        tol_r <= cfg_wdata;
      end
      lo2_r <= lo_w * lo_w;
      hi2_r <= hi_w * hi_w;
    end
  end

  // Point chain: cell k takes its neighbor k+1, so cell 0 shows point step_r.
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    fdpf_cell #(
      .PW(PW)
    ) u_cell (
      .clk      (clk),
      .shift_en (rotate),
      .shift_in (cell_pt[(k + 1) % MAX_POINTS]),
      .load_en  (load_fire && (cnt_r == CNTW'(k))),
      .load_pt  (load_pt),
      .pt_out   (cell_pt[k])
    );
  end

  // Distance unit against the captured query point.
  assign dist_en = adv && ((state_r == S_WALK) || (state_r == S_DRAIN));
  assign feed_v  = (state_r == S_WALK) && ({1'b0, step_r} < cnt_r);

  fdpf_dist #(
    .CB(COORD_BITS),
    .IW(IW)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (dist_en),
    .in_v    (feed_v),
    .in_idx  (step_r),
    .pa      (cell_pt[0]),
    .pb      (qpt_r),
    .lo2     (lo2_r),
    .hi2     (hi2_r),
    .hit_v   (hit_v),
    .hit_idx (hit_idx)
  );

  // Query point capture during the first rotation.
  assign qpt_cap = (state_r == S_FIND) && (step_ext == {{IW{1'b0}}, q_r});

  always_ff @(posedge clk) begin
    if (qpt_cap) begin
      qpt_r <= cell_pt[0];
    end
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      cnt_r    <= '0;
      q_r      <= '0;
      drain_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
      q_r      <= q_nxt;
      drain_r  <= drain_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    out_st_r   <= out_st_nxt;
    out_fi_r   <= out_fi_nxt;
    out_si_r   <= out_si_nxt;
    out_last_r <= out_last_nxt;
  end

  // Next state and result selection.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    q_nxt        = q_r;
    drain_nxt    = drain_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    out_v_nxt    = out_v_r && out_stall;
    out_st_nxt   = out_st_r;
    out_fi_nxt   = out_fi_r;
    out_si_nxt   = out_si_r;
    out_last_nxt = out_last_r;
    rotate       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_LOAD: begin
              if (full) begin
                out_v_nxt    = 1'b1;
                out_st_nxt   = ST_FULL;
                out_fi_nxt   = '0;
                out_si_nxt   = '0;
                out_last_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            CMD_QUERY: begin
              if ({{CNTW{1'b0}}, in_query_index} >= QW'(cnt_r)) begin
                out_v_nxt    = 1'b1;
                out_st_nxt   = ST_BAD_INDEX;
                out_fi_nxt   = in_query_index;
                out_si_nxt   = '0;
                out_last_nxt = 1'b1;
              end else begin
                q_nxt     = in_query_index;
                step_nxt  = '0;
                state_nxt = S_FIND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND: begin
        rotate   = 1'b1;
        step_nxt = step_last ? '0 : step_r + 1'b1;
        if (step_last) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (adv) begin
          rotate   = 1'b1;
          step_nxt = step_last ? '0 : step_r + 1'b1;
          if (step_last) begin
            drain_nxt = '0;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (adv) begin
          drain_nxt = drain_r + 1'b1;
          if (drain_r == 2'd2) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (adv) begin
          out_v_nxt    = 1'b1;
          out_fi_nxt   = q_r;
          out_last_nxt = 1'b1;
          if (pend_v_r) begin
            out_st_nxt = ST_PAIR;
            out_si_nxt = pend_ext[IDX_W-1:0];
          end else begin
            out_st_nxt = ST_NO_PAIR;
            out_si_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new hit sends the held pair out; the newest one is held until the final result.
    if (dist_en && hit_v) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_st_nxt   = ST_PAIR;
        out_fi_nxt   = q_r;
        out_si_nxt   = pend_ext[IDX_W-1:0];
        out_last_nxt = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_idx_nxt = hit_idx;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_st_r;
  assign out_first_index  = out_fi_r;
  assign out_second_index = out_si_r;
  assign out_last         = out_last_r;

endmodule

// ===== tb/fixed_distance_pair_finder_unit_test.sv =====
// Self-checking testbench for fixed_distance_pair_finder_unit: directed and random
// load, query and clear traffic under random valid and stall gaps, checked against a
// behavioral predictor of the point store. Depends on fdpf_pkg and the RTL only.
`timescale 1ns / 1ps

module fixed_distance_pair_finder_unit_test;
  import fdpf_pkg::*;

  localparam int NPTS = 64;
  localparam int SETTLE = 2 * NPTS + 20;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    cmd_t              cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [5:0]        q;
  } item_t;

  typedef struct {
    status_t    status;
    logic [5:0] first;
    logic [5:0] second;
    logic       last;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_NOP;
  logic signed [15:0] in_coord_x = '0;
  logic signed [15:0] in_coord_y = '0;
  logic signed [15:0] in_coord_z = '0;
  logic [5:0] in_query_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_first_index;
  logic [5:0] out_second_index;
  logic out_last;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_PAIR_DIST;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Pending stimulus, the item now on the bus and the results still owed.
  item_t        pending_items[$];
  item_t        bus_item;
  pair_result_t owed_results[$];

  // Predictor copy of the block's state and registers.
  longint store_x[NPTS];
  longint store_y[NPTS];
  longint store_z[NPTS];
  int     stored_count = 0;
  longint want_dist = 0;
  longint want_tol = 0;

  int  errors = 0;
  bit  calm = 1'b0;
  int  quiet_cycles = 0;

  fixed_distance_pair_finder_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Append one item to the stimulus queue.
  task automatic add_item(input item_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic owe(input status_t st, input logic [5:0] a, input logic [5:0] b,
                     input logic l);
    pair_result_t r;
    r.status = st;
    r.first  = a;
    r.second = b;
    r.last   = l;
    owed_results = {owed_results, r};
  endtask

  // Work out the results of one accepted item and update the store copy.
  task automatic predict_pairs(input item_t it);
    longint lo;
    longint hi;
    longint dx;
    longint dy;
    longint dz;
    longint d2;
    int     found;
    found = 0;
    case (it.cmd)
      CMD_LOAD: begin
        if (stored_count >= NPTS) begin
          owe(ST_FULL, '0, '0, 1'b1);
        end else begin
          store_x[stored_count] = it.x;
          store_y[stored_count] = it.y;
          store_z[stored_count] = it.z;
          stored_count++;
        end
      end
      CMD_CLEAR: stored_count = 0;
      CMD_QUERY: begin
        lo = (want_dist > want_tol) ? want_dist - want_tol : 0;
        hi = want_dist + want_tol;
        if (it.q >= stored_count) begin
          owe(ST_BAD_INDEX, it.q, '0, 1'b1);
        end else begin
          for (int j = 0; j < stored_count; j++) begin
            dx = store_x[it.q] - store_x[j];
            dy = store_y[it.q] - store_y[j];
            dz = store_z[it.q] - store_z[j];
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 >= lo * lo && d2 <= hi * hi) begin
              owe(ST_PAIR, it.q, j[5:0], 1'b0);
              found++;
            end
          end
          if (found == 0) owe(ST_NO_PAIR, it.q, '0, 1'b1);
          else owed_results[owed_results.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Driver: predict on each transfer, then present the next item or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_pairs(bus_item);
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          bus_item = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_cmd         <= bus_item.cmd;
          in_coord_x     <= bus_item.x;
          in_coord_y     <= bus_item.y;
          in_coord_z     <= bus_item.z;
          in_query_index <= bus_item.q;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest owed result.
  always @(posedge clk) begin
    pair_result_t r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report("result with nothing owed");
        end else begin
          r = owed_results.pop_front();
          if (out_status != r.status)
            report($sformatf("status %0d, wanted %0d", out_status, r.status));
          if (out_first_index != r.first)
            report($sformatf("first_index %0d, wanted %0d", out_first_index, r.first));
          if (out_second_index != r.second)
            report($sformatf("second_index %0d, wanted %0d", out_second_index, r.second));
          if (out_last != r.last)
            report($sformatf("last %0d, wanted %0d", out_last, r.last));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 15);
      // Watchdog on cycles without any transfer.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("fixed_distance_pair_finder_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic item_t make_item(input cmd_t c, input int x, input int y, input int z,
                                      input int q);
    item_t it;
    it.cmd = c;
    it.x = x[15:0];
    it.y = y[15:0];
    it.z = z[15:0];
    it.q = q[5:0];
    return it;
  endfunction

  // A point near distance d from the anchor along one axis, or a random point.
  function automatic item_t near_point(input item_t anchor, input int d, input int t);
    item_t it;
    int    off;
    it = anchor;
    if ($urandom_range(0, 9) < 3) begin
      it.x = 16'($urandom);
      it.y = 16'($urandom);
      it.z = 16'($urandom);
    end else begin
      off = d + $urandom_range(0, 2 * t + 4) - t - 2;
      if ($urandom_range(0, 1)) off = -off;
      case ($urandom_range(0, 2))
        0: it.x = it.x + off[15:0];
        1: it.y = it.y + off[15:0];
        default: it.z = it.z + off[15:0];
      endcase
    end
    return it;
  endfunction

  // One clustered phase: clear, load points around an anchor, then query them, with some no-ops and bad indexes.
  task automatic queue_phase(input int npts, input int nq, input int d, input int t);
    item_t anchor;
    anchor = make_item(CMD_LOAD, $urandom, $urandom, $urandom, 0);
    add_item(make_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
    add_item(anchor);
    for (int i = 1; i < npts; i++) add_item(near_point(anchor, d, t));
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_item(make_item(CMD_NOP, $urandom, $urandom, $urandom, $urandom));
      else if ($urandom_range(0, 9) == 0)
        add_item(make_item(CMD_QUERY, 0, 0, 0, $urandom_range(npts, 63)));
      else
        add_item(make_item(CMD_QUERY, $urandom, $urandom, $urandom,
                           $urandom_range(0, npts - 1)));
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PAIR_DIST) want_dist = value;
    else want_tol = value;
  endtask

  task automatic set_geometry(input int d, input int t);
    wait_idle();
    write_reg(REG_PAIR_DIST, d);
    write_reg(REG_TOL, t);
  endtask

  // Stimulus sequence.
  initial begin
    int d;
    int t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_geometry(5, 0);

    // Directed: coordinate extremes, an exact 3-4-5 pair, bad indexes, no-op, clear.
    add_item(make_item(CMD_LOAD, 0, 0, 0, 0));
    add_item(make_item(CMD_LOAD, 3, 4, 0, 0));
    add_item(make_item(CMD_LOAD, -32768, -32768, -32768, 0));
    add_item(make_item(CMD_LOAD, 32767, 32767, 32767, 0));
    add_item(make_item(CMD_LOAD, 5, 0, 0, 63));
    add_item(make_item(CMD_LOAD, -32768, 32767, -32768, 0));
    for (int i = 0; i < 6; i++)
      add_item(make_item(CMD_QUERY, 0, 0, 0, i));
    add_item(make_item(CMD_QUERY, 0, 0, 0, 6));
    add_item(make_item(CMD_QUERY, -1, -1, -1, 63));
    add_item(make_item(CMD_NOP, -1, -1, -1, 63));
    add_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
    add_item(make_item(CMD_QUERY, 0, 0, 0, 0));
    add_item(make_item(CMD_LOAD, 7, -7, 7, 0));
    add_item(make_item(CMD_QUERY, 0, 0, 0, 0));

    // Register extremes, each with a short clustered phase.
    set_geometry(0, 0);
    queue_phase(8, 8, 0, 0);
    set_geometry(131071, 131071);
    queue_phase(6, 4, 3000, 100);
    set_geometry(131071, 0);
    queue_phase(6, 4, 3000, 100);
    set_geometry(0, 131071);
    queue_phase(5, 3, 500, 50);

    // Fill the store past its end, then query the top and bottom entries.
    set_geometry(1000, 20);
    calm = 1'b1;
    queue_phase(64, 0, 1000, 20);
    add_item(make_item(CMD_LOAD, 1, 2, 3, 0));
    add_item(make_item(CMD_LOAD, -1, -2, -3, 0));
    add_item(make_item(CMD_QUERY, 0, 0, 0, 63));
    add_item(make_item(CMD_QUERY, 0, 0, 0, 0));
    wait_idle();
    calm = 1'b0;

    // Random phases with small geometry, every third one without idling.
    for (int p = 0; p < 6; p++) begin
      d = $urandom_range(1, 3000);
      t = $urandom_range(0, d / 4);
      set_geometry(d, t);
      calm = (p % 3 == 2);
      queue_phase($urandom_range(2, 16), $urandom_range(6, 14), d, t);
    end

    wait_idle();
    if (errors == 0) begin
      $display("fixed_distance_pair_finder_unit regression: pass");
    end else begin
      $display("fixed_distance_pair_finder_unit regression: fail");
    end
    $finish;
  end

endmodule
